>>> rtl/core/uph_pkg.sv
// shared types and constants for the pdu header parser
package uph_pkg;

  localparam int unsigned MAX_LENGTH_INDICATORS = 32;
  localparam int unsigned LI_CNT_W = 6;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_LI_A    = 3'd2,
    PH_LI_B    = 3'd3,
    PH_LI_C    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_LI      = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  // one parsed result as it leaves the step logic
  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic [1:0]  framing_info;
    logic [9:0]  seq_number;
    logic [10:0] length_value;
    logic [4:0]  li_position;
    logic [7:0]  payload_value;
    logic        pdu_end;
  } result_t;

endpackage

>>> rtl/core/uph_parser.sv
// parse state registers and per-item step logic
module uph_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             sn_long_mode,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output uph_pkg::result_t result
);
  import uph_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic                  more_r, more_nxt;
  logic [LI_CNT_W-1:0]   li_cnt_r, li_cnt_nxt;
  logic [10:0]           partial_r, partial_nxt;
  logic [1:0]            framing_r, framing_nxt;
  logic [1:0]            sn_high_r, sn_high_nxt;

  logic                  li_limit;
  logic                  err;
  logic [10:0]           li_b_val;
  logic [10:0]           li_c_val;
  logic [LI_CNT_W-1:0]   li_cnt_inc;

  assign li_limit   = li_cnt_r >= LI_CNT_W'(MAX_LENGTH_INDICATORS);
  assign li_b_val   = partial_r | {7'd0, data_byte[7:4]};
  assign li_c_val   = partial_r | {3'd0, data_byte};
  assign li_cnt_inc = li_cnt_r + LI_CNT_W'(1);

  // error decode shared by next state and result
  always_comb begin
    err = 1'b0;
    case (phase_r)
      PH_FIRST: begin
        if (sn_long_mode) err = last_byte;
        else              err = data_byte[5] & last_byte;
      end
      PH_SECOND: err = more_r & last_byte;
      PH_LI_A:   err = last_byte;
      PH_LI_B:   err = li_limit | (more_r & last_byte);
      PH_LI_C:   err = li_limit | (more_r & last_byte);
      default:   err = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    more_nxt    = more_r;
    li_cnt_nxt  = li_cnt_r;
    partial_nxt = partial_r;
    framing_nxt = framing_r;
    sn_high_nxt = sn_high_r;
    case (phase_r)
      PH_FIRST: begin
        li_cnt_nxt = '0;
        if (sn_long_mode) begin
          framing_nxt = data_byte[4:3];
          more_nxt    = data_byte[2];
          sn_high_nxt = data_byte[1:0];
          phase_nxt   = PH_SECOND;
        end else begin
          more_nxt  = data_byte[5];
          phase_nxt = data_byte[5] ? PH_LI_A : PH_PAYLOAD;
        end
      end
      PH_SECOND: phase_nxt = more_r ? PH_LI_A : PH_PAYLOAD;
      PH_LI_A: begin
        more_nxt    = data_byte[7];
        partial_nxt = {data_byte[6:0], 4'd0};
        phase_nxt   = PH_LI_B;
      end
      PH_LI_B: begin
        if (!li_limit) begin
          li_cnt_nxt = li_cnt_inc;
          if (more_r) begin
            more_nxt    = data_byte[3];
            partial_nxt = {data_byte[2:0], 8'd0};
            phase_nxt   = PH_LI_C;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_LI_C: begin
        if (!li_limit) begin
          li_cnt_nxt = li_cnt_inc;
          phase_nxt  = more_r ? PH_LI_A : PH_PAYLOAD;
        end
      end
      default: phase_nxt = phase_r;
    endcase
    if (err) phase_nxt = PH_DISCARD;
    if (last_byte) begin
      phase_nxt   = PH_FIRST;
      more_nxt    = 1'b0;
      li_cnt_nxt  = '0;
      partial_nxt = '0;
      framing_nxt = '0;
      sn_high_nxt = '0;
    end
  end

  // result
  always_comb begin
    result         = '0;
    result.pdu_end = last_byte;
    case (phase_r)
      PH_FIRST: begin
        if (!sn_long_mode) begin
          result.emit         = 1'b1;
          result.kind         = KIND_HEADER;
          result.framing_info = data_byte[7:6];
          result.seq_number   = {5'd0, data_byte[4:0]};
        end
      end
      PH_SECOND: begin
        result.emit         = 1'b1;
        result.kind         = KIND_HEADER;
        result.framing_info = framing_r;
        result.seq_number   = {sn_high_r, data_byte};
      end
      PH_LI_B: begin
        result.emit         = 1'b1;
        result.kind         = KIND_LI;
        result.length_value = li_b_val;
        result.li_position  = li_cnt_r[4:0];
      end
      PH_LI_C: begin
        result.emit         = 1'b1;
        result.kind         = KIND_LI;
        result.length_value = li_c_val;
        result.li_position  = li_cnt_r[4:0];
      end
      PH_PAYLOAD: begin
        result.emit          = 1'b1;
        result.kind          = KIND_PAYLOAD;
        result.payload_value = data_byte;
      end
      default: result.emit = 1'b0;
    endcase
    if (err) begin
      result         = '0;
      result.emit    = 1'b1;
      result.kind    = KIND_ERROR;
      result.pdu_end = last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FIRST;
      more_r    <= 1'b0;
      li_cnt_r  <= '0;
      partial_r <= '0;
      framing_r <= '0;
      sn_high_r <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      more_r    <= more_nxt;
      li_cnt_r  <= li_cnt_nxt;
      partial_r <= partial_nxt;
      framing_r <= framing_nxt;
      sn_high_r <= sn_high_nxt;
    end
  end

endmodule

>>> rtl/core/um_pdu_header_parser_core.sv
// top level of the unacknowledged-mode pdu header parser
// a byte accepted into the input register is stepped once the result slot is free or
// being emptied, and its result is offered from the result register; throughput: one
// byte per cycle unless out_stall holds a full result slot, set by the single parse
// step between registers; a byte that yields no result (first header byte in long
// mode, first li byte of a pair, discarded bytes after an error) still takes a step
// reset: synchronous active-low rst_n clears parse state, both valids and sn mode
module um_pdu_header_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_framing_info,
  output logic [9:0]  out_seq_number,
  output logic [10:0] out_length_value,
  output logic [4:0]  out_li_position,
  output logic [7:0]  out_payload_value,
  output logic        out_pdu_end
);
  import uph_pkg::*;

  // sequence-number size, written by cfg_wr_en and read on the first byte of each pdu
  logic       sn_long_mode_r;

  // input register stage
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // result register stage
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    step_res;

  logic       in_accept;
  logic       advance;

  // the parse step fires when an item is held and the result slot is free
  // or being emptied this cycle
  assign advance   = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = in_valid_r & ~advance;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sn_long_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      sn_long_mode_r <= cfg_wr_data;
    end
  end

  // input register: refills in the same cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  uph_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .sn_long_mode (sn_long_mode_r),
    .data_byte    (in_byte_r),
    .last_byte    (in_last_r),
    .result       (step_res)
  );

  // result register: bytes without a result leave the slot empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_res.emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_framing_info  = out_res_r.framing_info;
  assign out_seq_number    = out_res_r.seq_number;
  assign out_length_value  = out_res_r.length_value;
  assign out_li_position   = out_res_r.li_position;
  assign out_payload_value = out_res_r.payload_value;
  assign out_pdu_end       = out_res_r.pdu_end;

endmodule
